FILE: src/rfp_pkg.sv
// Shared types, constants and helper functions for the relation file name parser.
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int CharW = 8;
  localparam int NumW  = 32;
  localparam int ForkW = 3;
  localparam int PosW  = 2;

  localparam logic [CharW-1:0] CH_NUL        = 8'h00;
  localparam logic [CharW-1:0] CH_ZERO       = "0";
  localparam logic [CharW-1:0] CH_ONE        = "1";
  localparam logic [CharW-1:0] CH_NINE       = "9";
  localparam logic [CharW-1:0] CH_UNDERSCORE = "_";
  localparam logic [CharW-1:0] CH_DOT        = ".";
  localparam logic [CharW-1:0] CH_F          = "f";
  localparam logic [CharW-1:0] CH_V          = "v";
  localparam logic [CharW-1:0] CH_I          = "i";

  localparam logic [ForkW-1:0] FORK_MAIN    = 3'd0;
  localparam logic [ForkW-1:0] FORK_FSM     = 3'd1;
  localparam logic [ForkW-1:0] FORK_VM      = 3'd2;
  localparam logic [ForkW-1:0] FORK_INIT    = 3'd3;
  localparam logic [ForkW-1:0] FORK_INVALID = 3'd4;

  typedef struct packed {
    logic              is_relation;
    logic [NumW-1:0]   rel_number;
    logic [ForkW-1:0]  fork_code;
    logic [NumW-1:0]   segment;
  } rfp_result_t;

  // acc * 10 + digit; top bit flags a result past 32 bits
  function automatic logic [NumW:0] add_digit(input logic [NumW-1:0] acc,
                                              input logic [CharW-1:0] c);
    logic [NumW+3:0] wide;
    logic [CharW-1:0] d;
    d    = c - CH_ZERO;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{(NumW-4){1'b0}}, d};
    return {|wide[NumW+3:NumW], wide[NumW-1:0]};
  endfunction

  function automatic logic [2:0] fork_len(input logic [ForkW-1:0] sel);
    case (sel[1:0])
      2'd1:    return 3'd3;
      2'd2:    return 3'd2;
      2'd3:    return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [CharW-1:0] fork_char(input logic [ForkW-1:0] sel,
                                                 input logic [PosW-1:0] pos);
    case ({sel[1:0], pos})
      4'b01_00: return "f";
      4'b01_01: return "s";
      4'b01_10: return "m";
      4'b10_00: return "v";
      4'b10_01: return "m";
      4'b11_00: return "i";
      4'b11_01: return "n";
      4'b11_10: return "i";
      4'b11_11: return "t";
      default:  return CH_NUL;
    endcase
  endfunction

endpackage

FILE: src/rfp_if.sv
// Valid/ready channel interfaces for name characters and parse results.
`timescale 1ns / 1ps

interface rfp_in_if;
  logic                      valid;
  logic                      ready;
  logic [rfp_pkg::CharW-1:0] name_char;

  modport source (output valid, output name_char, input ready);
  modport sink   (input valid, input name_char, output ready);
endinterface

interface rfp_out_if;
  logic                      valid;
  logic                      ready;
  logic                      is_relation;
  logic [rfp_pkg::NumW-1:0]  rel_number;
  logic [rfp_pkg::ForkW-1:0] fork_code;
  logic [rfp_pkg::NumW-1:0]  segment;

  modport source (output valid, output is_relation, output rel_number,
                  output fork_code, output segment, input ready);
  modport sink   (input valid, input is_relation, input rel_number,
                  input fork_code, input segment, output ready);
endinterface

FILE: src/rfp_scan.sv
// Name scanner: parse state registers and the one-character step logic.
`timescale 1ns / 1ps

module rfp_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [rfp_pkg::CharW-1:0] name_char,
  output logic                      emit,
  output rfp_pkg::rfp_result_t      result
);

  typedef enum logic [2:0] {
    PH_START     = 3'd0,
    PH_REL       = 3'd1,
    PH_FORK      = 3'd2,
    PH_AFTERFORK = 3'd3,
    PH_SEGFIRST  = 3'd4,
    PH_SEG       = 3'd5,
    PH_REJECT    = 3'd6
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [rfp_pkg::NumW-1:0]    rel_accum_r, rel_accum_nxt;
  logic [rfp_pkg::NumW-1:0]    seg_accum_r, seg_accum_nxt;
  logic [rfp_pkg::ForkW-1:0]   fork_sel_r, fork_sel_nxt;
  logic [rfp_pkg::PosW-1:0]    fork_pos_r, fork_pos_nxt;

  logic                        is_nul, is_digit, is_lead;
  logic [rfp_pkg::NumW:0]      rel_add, seg_add;
  logic                        emit_ok;

  assign is_nul   = (name_char == rfp_pkg::CH_NUL);
  assign is_digit = name_char inside {[rfp_pkg::CH_ZERO:rfp_pkg::CH_NINE]};
  assign is_lead  = name_char inside {[rfp_pkg::CH_ONE:rfp_pkg::CH_NINE]};
  assign rel_add  = rfp_pkg::add_digit(rel_accum_r, name_char);
  assign seg_add  = rfp_pkg::add_digit(seg_accum_r, name_char);

  always_comb begin
    logic [rfp_pkg::ForkW-1:0] sel_v;
    logic                      bad_v;
    logic [2:0]                pos_inc;
    phase_nxt     = phase_r;
    rel_accum_nxt = rel_accum_r;
    seg_accum_nxt = seg_accum_r;
    fork_sel_nxt  = fork_sel_r;
    fork_pos_nxt  = fork_pos_r;
    emit          = 1'b0;
    emit_ok       = 1'b0;
    sel_v         = fork_sel_r;
    bad_v         = 1'b0;
    pos_inc       = {1'b0, fork_pos_r} + 3'd1;
    case (phase_r)
      PH_START: begin
        if (is_nul) begin
          emit = 1'b1;
        end else if (is_lead) begin
          rel_accum_nxt = {{(rfp_pkg::NumW-rfp_pkg::CharW){1'b0}},
                           name_char - rfp_pkg::CH_ZERO};
          phase_nxt     = PH_REL;
        end else begin
          phase_nxt = PH_REJECT;
        end
      end
      PH_REL: begin
        if (is_nul) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else if (is_digit) begin
          if (rel_add[rfp_pkg::NumW]) phase_nxt = PH_REJECT;
          else rel_accum_nxt = rel_add[rfp_pkg::NumW-1:0];
        end else if (name_char == rfp_pkg::CH_UNDERSCORE) begin
          phase_nxt    = PH_FORK;
          fork_pos_nxt = '0;
        end else if (name_char == rfp_pkg::CH_DOT) begin
          phase_nxt = PH_SEGFIRST;
        end else begin
          phase_nxt = PH_REJECT;
        end
      end
      PH_FORK: begin
        if (is_nul) begin
          emit = 1'b1;
        end else begin
          if (fork_pos_r == '0) begin
            case (name_char)
              rfp_pkg::CH_F: sel_v = rfp_pkg::FORK_FSM;
              rfp_pkg::CH_V: sel_v = rfp_pkg::FORK_VM;
              rfp_pkg::CH_I: sel_v = rfp_pkg::FORK_INIT;
              default:       bad_v = 1'b1;
            endcase
          end
          fork_sel_nxt = sel_v;
          if (!bad_v && (sel_v[1:0] == 2'd0 ||
                         {1'b0, fork_pos_r} >= rfp_pkg::fork_len(sel_v) ||
                         rfp_pkg::fork_char(sel_v, fork_pos_r) != name_char)) begin
            bad_v = 1'b1;
          end
          if (bad_v) begin
            phase_nxt = PH_REJECT;
          end else if (pos_inc >= rfp_pkg::fork_len(sel_v)) begin
            phase_nxt    = PH_AFTERFORK;
            fork_pos_nxt = '0;
          end else begin
            fork_pos_nxt = pos_inc[rfp_pkg::PosW-1:0];
          end
        end
      end
      PH_AFTERFORK: begin
        if (is_nul) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else begin
          phase_nxt = (name_char == rfp_pkg::CH_DOT) ? PH_SEGFIRST : PH_REJECT;
        end
      end
      PH_SEGFIRST: begin
        if (is_nul) begin
          emit = 1'b1;
        end else if (is_lead) begin
          seg_accum_nxt = {{(rfp_pkg::NumW-rfp_pkg::CharW){1'b0}},
                           name_char - rfp_pkg::CH_ZERO};
          phase_nxt     = PH_SEG;
        end else begin
          phase_nxt = PH_REJECT;
        end
      end
      PH_SEG: begin
        if (is_nul) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end else if (!is_digit || seg_add[rfp_pkg::NumW]) begin
          phase_nxt = PH_REJECT;
        end else begin
          seg_accum_nxt = seg_add[rfp_pkg::NumW-1:0];
        end
      end
      default: begin
        if (is_nul) emit = 1'b1;
        else phase_nxt = PH_REJECT;
      end
    endcase
    // a terminator always restarts the parser
    if (emit) begin
      phase_nxt     = PH_START;
      rel_accum_nxt = '0;
      seg_accum_nxt = '0;
      fork_sel_nxt  = rfp_pkg::FORK_MAIN;
      fork_pos_nxt  = '0;
    end
  end

  always_comb begin
    result.is_relation = emit_ok;
    result.rel_number  = emit_ok ? rel_accum_r : '0;
    result.fork_code   = emit_ok ? fork_sel_r : rfp_pkg::FORK_INVALID;
    result.segment     = emit_ok ? seg_accum_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      rel_accum_r <= '0;
      seg_accum_r <= '0;
      fork_sel_r  <= rfp_pkg::FORK_MAIN;
      fork_pos_r  <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      rel_accum_r <= rel_accum_nxt;
      seg_accum_r <= seg_accum_nxt;
      fork_sel_r  <= fork_sel_nxt;
      fork_pos_r  <= fork_pos_nxt;
    end
  end

endmodule

FILE: src/relation_filename_parser.sv
// Top level of the relation file name parser: input register, scanner, result register.
`timescale 1ns / 1ps

// Takes one name character per request and can accept a new one every cycle
// unless stalled. A character is held in the input register and scanned there
// against the parse state; a terminator (zero byte) loads one result into the
// output register. The only stall is a terminator in the input register while
// the previous result has not been taken; plain characters never wait on the
// output side.

module relation_filename_parser (
  input logic        clk,
  input logic        rst_n,
  rfp_in_if.sink     in_ch,
  rfp_out_if.source  out_ch
);

  logic                       in_valid_r;
  logic [rfp_pkg::CharW-1:0]  in_char_r;
  logic                       out_valid_r;
  rfp_pkg::rfp_result_t       out_data_r;

  logic                       emit;
  logic                       step_en;
  logic                       blocked;
  rfp_pkg::rfp_result_t       result;

  assign blocked     = (in_char_r == rfp_pkg::CH_NUL) && out_valid_r && !out_ch.ready;
  assign step_en     = in_valid_r && !blocked;
  assign in_ch.ready = !in_valid_r || step_en;

  rfp_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .name_char (in_char_r),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) in_char_r <= in_ch.name_char;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) out_data_r <= result;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_relation = out_data_r.is_relation;
  assign out_ch.rel_number  = out_data_r.rel_number;
  assign out_ch.fork_code   = out_data_r.fork_code;
  assign out_ch.segment     = out_data_r.segment;

endmodule

FILE: tb/sv/relation_filename_parser_checker.sv
// Scoreboard for the relation file name parser: predicts each parse result and compares.
`timescale 1ns / 1ps

module relation_filename_parser_checker (
  input  logic clk,
  input  logic rst_n,
  rfp_in_if    in_ch,
  rfp_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_results
);

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_REL,
    SCAN_FORK,
    SCAN_AFTER_FORK,
    SCAN_SEG_FIRST,
    SCAN_SEG,
    SCAN_REJECT
  } scan_phase_t;

  scan_phase_t                phase;
  logic [rfp_pkg::NumW-1:0]   rel_acc;
  logic [rfp_pkg::NumW-1:0]   seg_acc;
  logic [rfp_pkg::ForkW-1:0]  fork_sel;
  logic [rfp_pkg::PosW-1:0]   fork_pos;
  rfp_pkg::rfp_result_t       parse_results_q[$];
  int                         fail_tally = 0;
  string                      fork_names[4] = '{"", "fsm", "vm", "init"};

  function automatic bit is_digit(input logic [rfp_pkg::CharW-1:0] c);
    return c >= rfp_pkg::CH_ZERO && c <= rfp_pkg::CH_NINE;
  endfunction

  function automatic bit is_lead(input logic [rfp_pkg::CharW-1:0] c);
    return c >= rfp_pkg::CH_ONE && c <= rfp_pkg::CH_NINE;
  endfunction

  // {overflow, acc * 10 + digit}
  function automatic logic [rfp_pkg::NumW:0] append_digit(
      input logic [rfp_pkg::NumW-1:0] acc,
      input logic [rfp_pkg::CharW-1:0] c);
    logic [rfp_pkg::CharW-1:0] d;
    logic [63:0]               v;
    d = c - rfp_pkg::CH_ZERO;
    v = 64'(acc) * 64'd10 + 64'(d);
    return {(v > 64'hFFFF_FFFF), v[rfp_pkg::NumW-1:0]};
  endfunction

  function automatic void clear_scan();
    phase    = SCAN_START;
    rel_acc  = '0;
    seg_acc  = '0;
    fork_sel = rfp_pkg::FORK_MAIN;
    fork_pos = '0;
  endfunction

  function automatic void close_name(input bit ok);
    rfp_pkg::rfp_result_t r;
    r.is_relation = ok;
    r.rel_number  = ok ? rel_acc : '0;
    r.fork_code   = ok ? fork_sel : rfp_pkg::FORK_INVALID;
    r.segment     = ok ? seg_acc : '0;
    parse_results_q.push_back(r);
    clear_scan();
  endfunction

  function automatic void parse_char(input logic [rfp_pkg::CharW-1:0] c);
    logic [rfp_pkg::NumW:0] sum;
    logic [1:0]             sel;
    int                     pos;
    int                     pos_next;
    bit                     bad;
    bad      = 1'b0;
    pos      = int'(fork_pos);
    pos_next = pos + 1;
    case (phase)
      SCAN_START: begin
        if (c == rfp_pkg::CH_NUL) close_name(1'b0);
        else if (is_lead(c)) begin
          rel_acc = {{(rfp_pkg::NumW-rfp_pkg::CharW){1'b0}}, c - rfp_pkg::CH_ZERO};
          phase   = SCAN_REL;
        end else phase = SCAN_REJECT;
      end
      SCAN_REL: begin
        if (c == rfp_pkg::CH_NUL) close_name(1'b1);
        else if (is_digit(c)) begin
          sum = append_digit(rel_acc, c);
          if (sum[rfp_pkg::NumW]) phase = SCAN_REJECT;
          else rel_acc = sum[rfp_pkg::NumW-1:0];
        end else if (c == rfp_pkg::CH_UNDERSCORE) begin
          phase    = SCAN_FORK;
          fork_pos = '0;
        end else if (c == rfp_pkg::CH_DOT) phase = SCAN_SEG_FIRST;
        else phase = SCAN_REJECT;
      end
      SCAN_FORK: begin
        if (c == rfp_pkg::CH_NUL) close_name(1'b0);
        else begin
          if (pos == 0) begin
            if (c == rfp_pkg::CH_F) fork_sel = rfp_pkg::FORK_FSM;
            else if (c == rfp_pkg::CH_V) fork_sel = rfp_pkg::FORK_VM;
            else if (c == rfp_pkg::CH_I) fork_sel = rfp_pkg::FORK_INIT;
            else bad = 1'b1;
          end
          sel = fork_sel[1:0];
          if (!bad && (sel == 2'd0 || pos >= fork_names[sel].len() ||
                       fork_names[sel][pos] != c))
            bad = 1'b1;
          if (bad) phase = SCAN_REJECT;
          else if (pos_next >= fork_names[sel].len()) begin
            phase    = SCAN_AFTER_FORK;
            fork_pos = '0;
          end else fork_pos = pos_next[rfp_pkg::PosW-1:0];
        end
      end
      SCAN_AFTER_FORK: begin
        if (c == rfp_pkg::CH_NUL) close_name(1'b1);
        else phase = (c == rfp_pkg::CH_DOT) ? SCAN_SEG_FIRST : SCAN_REJECT;
      end
      SCAN_SEG_FIRST: begin
        if (c == rfp_pkg::CH_NUL) close_name(1'b0);
        else if (is_lead(c)) begin
          seg_acc = {{(rfp_pkg::NumW-rfp_pkg::CharW){1'b0}}, c - rfp_pkg::CH_ZERO};
          phase   = SCAN_SEG;
        end else phase = SCAN_REJECT;
      end
      SCAN_SEG: begin
        if (c == rfp_pkg::CH_NUL) close_name(1'b1);
        else if (!is_digit(c)) phase = SCAN_REJECT;
        else begin
          sum = append_digit(seg_acc, c);
          if (sum[rfp_pkg::NumW]) phase = SCAN_REJECT;
          else seg_acc = sum[rfp_pkg::NumW-1:0];
        end
      end
      default: begin
        if (c == rfp_pkg::CH_NUL) close_name(1'b0);
        else phase = SCAN_REJECT;
      end
    endcase
  endfunction

  function automatic void check_result();
    rfp_pkg::rfp_result_t want;
    if (parse_results_q.size() == 0) begin
      $error("parse result with no name pending");
      fail_tally++;
    end else begin
      want = parse_results_q.pop_front();
      if (out_ch.is_relation !== want.is_relation) begin
        $error("is_relation: expected %0d, got %0d", want.is_relation, out_ch.is_relation);
        fail_tally++;
      end
      if (out_ch.rel_number !== want.rel_number) begin
        $error("rel_number: expected %0d, got %0d", want.rel_number, out_ch.rel_number);
        fail_tally++;
      end
      if (out_ch.fork_code !== want.fork_code) begin
        $error("fork_code: expected %0d, got %0d", want.fork_code, out_ch.fork_code);
        fail_tally++;
      end
      if (out_ch.segment !== want.segment) begin
        $error("segment: expected %0d, got %0d", want.segment, out_ch.segment);
        fail_tally++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      parse_results_q.delete();
    end else begin
      // results leave only after their terminator has passed the input and output registers, so check before predicting
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) parse_char(in_ch.name_char);
    end
    mismatch_count  <= fail_tally;
    pending_results <= parse_results_q.size();
  end

endmodule

FILE: tb/sv/relation_filename_parser_tb.sv
// Testbench top for the relation file name parser: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps

module relation_filename_parser_tb;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_EVERY_FOURTH, RX_RARE_STALL} stall_mode_t;

  localparam int NumRandomChars = 1600;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   burst_left = 0;
  logic [rfp_pkg::CharW-1:0] char_q[$];

  rfp_in_if  name_ch ();
  rfp_out_if result_ch ();

  relation_filename_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (name_ch),
    .out_ch (result_ch)
  );

  relation_filename_parser_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (name_ch),
    .out_ch          (result_ch),
    .mismatch_count  (mismatches),
    .pending_results (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endfunction

  function automatic string number_text();
    int unsigned v;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) v = $urandom_range(1, 999);
    else if (pick < 70) v = $urandom_range(1000, 999999999);
    else if (pick < 85) v = $urandom;
    else v = 32'hFFFF_FFFF - $urandom_range(0, 9);
    if (v == 0) v = 1;
    return $sformatf("%0d", v);
  endfunction

  function automatic string overflow_text();
    longint unsigned v;
    v = 64'd4294967296 + 64'($urandom_range(0, 9));
    if ($urandom_range(0, 1)) v = v + 64'($urandom);
    if ($urandom_range(0, 3) == 0) v = v * 64'd10;
    return $sformatf("%0d", v);
  endfunction

  function automatic string fork_word();
    case ($urandom_range(0, 2))
      0:       return "fsm";
      1:       return "vm";
      default: return "init";
    endcase
  endfunction

  function automatic string fork_suffix();
    if ($urandom_range(0, 3) == 0) return "";
    return {"_", fork_word()};
  endfunction

  // one name plus its terminator; most are well formed, the rest broken or noise
  function automatic void queue_name();
    string                     n, f, s, text, word;
    int                        k;
    logic [rfp_pkg::CharW-1:0] extra;
    n = number_text();
    f = fork_suffix();
    s = $urandom_range(0, 1) ? {".", number_text()} : "";
    if ($urandom_range(0, 99) < 65) push_text({n, f, s});
    else begin
      case ($urandom_range(0, 7))
        0: repeat ($urandom_range(1, 6))
             char_q.push_back(rfp_pkg::CharW'($urandom_range(0, 255)));
        1: begin
          text = {n, f, s};
          k = $urandom_range(0, text.len() - 1);
          extra = rfp_pkg::CharW'($urandom_range(1, 255));
          text[k] = extra;
          push_text(text);
        end
        2: begin
          word = fork_word();
          push_text({n, "_"});
          k = $urandom_range(0, word.len() - 1);
          for (int i = 0; i < k; i++) char_q.push_back(word[i]);
        end
        3: begin
          push_text({n, f, "."});
          case ($urandom_range(0, 2))
            0: char_q.push_back(rfp_pkg::CH_ZERO);
            1: char_q.push_back(rfp_pkg::CharW'($urandom_range(1, 255)));
            default: ;
          endcase
        end
        4: begin
          if ($urandom_range(0, 1)) push_text({overflow_text(), f, s});
          else push_text({n, f, ".", overflow_text()});
        end
        5: begin
          if ($urandom_range(0, 1)) push_text({"0", n});
          else push_text({n, f, ".0", n});
        end
        6: begin
          extra = rfp_pkg::CharW'($urandom_range(1, 255));
          if (extra == rfp_pkg::CH_DOT) extra = "x";
          push_text({n, "_", fork_word()});
          char_q.push_back(extra);
        end
        default: ;
      endcase
    end
    char_q.push_back(rfp_pkg::CH_NUL);
  endfunction

  task automatic send_char(input logic [rfp_pkg::CharW-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        name_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    name_ch.valid     <= 1'b1;
    name_ch.name_char <= c;
    @(posedge clk);
    while (!name_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  initial begin
    int sent;
    int wait_cycles;
    sent = 0;
    wait_cycles = 0;
    rst_n             <= 1'b0;
    name_ch.valid     <= 1'b0;
    name_ch.name_char <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty name, largest number, cut fork, missing segment, early reject, fork prefix
    char_q.push_back(rfp_pkg::CH_NUL);
    push_text("4294967295");
    char_q.push_back(rfp_pkg::CH_NUL);
    push_text("1_fs");
    char_q.push_back(rfp_pkg::CH_NUL);
    push_text("2.");
    char_q.push_back(rfp_pkg::CH_NUL);
    char_q.push_back(8'hFF);
    char_q.push_back(rfp_pkg::CH_NUL);
    push_text("3_vmx");
    char_q.push_back(rfp_pkg::CH_NUL);

    while (sent < NumRandomChars || char_q.size() > 0) begin
      if (char_q.size() == 0) queue_name();
      send_char(char_q.pop_front());
      sent++;
    end
    name_ch.valid <= 1'b0;

    // let the pending count catch up with the last request
    @(posedge clk);
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int          stretch;
    int          len;
    int          hold;
    stall_mode_t mode;
    stretch = 0;
    result_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stretch == 3) begin
        // long hold-off so that a second terminator backs up into the input
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          result_ch.ready <= 1'b0;
          hold++;
        end
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        len  = $urandom_range(20, 200);
        for (int i = 0; i < len; i++) begin
          @(posedge clk);
          case (mode)
            RX_ALWAYS:       result_ch.ready <= 1'b1;
            RX_COIN:         result_ch.ready <= 1'($urandom_range(0, 1));
            RX_EVERY_FOURTH: result_ch.ready <= (i % 4 == 0);
            default:         result_ch.ready <= ($urandom_range(0, 9) != 0);
          endcase
        end
      end
      stretch++;
    end
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
src/rfp_pkg.sv
src/rfp_if.sv
src/rfp_scan.sv
src/relation_filename_parser.sv
tb/sv/relation_filename_parser_checker.sv
tb/sv/relation_filename_parser_tb.sv
